// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_AT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("%m: check failed");
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  `ASSERT_AT(lbl, clk_s, rstn_s, !(cond))
`else
`define ASSERT_AT(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

// ----- sv/bis_pkg.sv -----
// ---------------------------------------------------------------------------
// Bilinear scaler package
// Widths, reset values, codes and payload types of the scaler pipeline.
// ---------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam int COORD_W     = 16;
  localparam int PIX_W       = 8;
  localparam int DIM_W       = 9;
  localparam int SCALE_W     = 24;
  localparam int FRAC_W      = 16;
  localparam int POS_W       = COORD_W + SCALE_W;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int HBLEND_W    = PIX_W + FRAC_W;
  localparam int VBLEND_W    = WGT_W + HBLEND_W;
  localparam int DIM_EXT_W   = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 2 * COORD_W + PIX_W;
  localparam int OUT_TDATA_W = PIX_W;

  localparam logic [DIM_W-1:0]   ROWS_RST  = 9'd256;
  localparam logic [DIM_W-1:0]   COLS_RST  = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;
  localparam logic [WGT_W-1:0]   WGT_ONE   = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_ROWS = 2'd0,
    CFG_IMAGE_COLS = 2'd1,
    CFG_INV_SCALE  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fr;
    logic [FRAC_W-1:0] fc;
  } frac_t;

  typedef struct packed {
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p11;
  } quad_t;

endpackage

// ----- sv/bis_map.sv -----
// ---------------------------------------------------------------------------
// Bilinear scaler coordinate map
// Scales a request's coordinate and clamps its neighbour rows and columns; loads pass through.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bis_map #(
  parameter int MAX_ROWS = bis_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bis_pkg::MAX_COLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bis_pkg::kind_t                       in_kind,
  input  logic [bis_pkg::COORD_W-1:0]          in_row,
  input  logic [bis_pkg::COORD_W-1:0]          in_col,
  input  logic [bis_pkg::PIX_W-1:0]            in_pix,
  input  logic [bis_pkg::SCALE_W-1:0]          inv_scale,
  input  logic [$clog2(MAX_ROWS)-1:0]          last_row,
  input  logic [$clog2(MAX_COLS)-1:0]          last_col,
  input  logic                                 s3_ready,
  output logic                                 s2_valid,
  output bis_pkg::kind_t                       s2_kind,
  output logic                                 s2_wr_ok,
  output logic [$clog2(MAX_ROWS)-1:0]          s2_r0,
  output logic [$clog2(MAX_ROWS)-1:0]          s2_r1,
  output logic [$clog2(MAX_COLS)-1:0]          s2_c0,
  output logic [$clog2(MAX_COLS)-1:0]          s2_c1,
  output bis_pkg::frac_t                       s2_frac,
  output logic [bis_pkg::PIX_W-1:0]            s2_pix
);
  import bis_pkg::*;

  localparam int RIDX_W  = $clog2(MAX_ROWS);
  localparam int CIDX_W  = $clog2(MAX_COLS);
  localparam int IPART_W = POS_W - FRAC_W;

  logic                 v1_r, v2_r;
  logic                 en1, en2;
  kind_t                kind1_r, kind2_r;
  logic [COORD_W-1:0]   row1_r, col1_r;
  logic [PIX_W-1:0]     pix1_r, pix2_r;
  logic [POS_W-1:0]     pr1_r, pc1_r;

  logic [IPART_W:0]     ir_ext, ic_ext, ir_inc, ic_inc, lr_ext, lc_ext;
  logic [RIDX_W-1:0]    r0_nxt, r1_nxt, r0_r, r1_r;
  logic [CIDX_W-1:0]    c0_nxt, c1_nxt, c0_r, c1_r;
  logic                 wr_ok_nxt, wr_ok_r;
  frac_t                frac_nxt, frac_r;

  assign en2      = !v2_r || s3_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1_r <= in_kind;
      row1_r  <= in_row;
      col1_r  <= in_col;
      pix1_r  <= in_pix;
      pr1_r   <= POS_W'(in_row) * POS_W'(inv_scale);
      pc1_r   <= POS_W'(in_col) * POS_W'(inv_scale);
    end
  end

  always_comb begin
    ir_ext    = {1'b0, pr1_r[POS_W-1:FRAC_W]};
    ic_ext    = {1'b0, pc1_r[POS_W-1:FRAC_W]};
    ir_inc    = ir_ext + 1'b1;
    ic_inc    = ic_ext + 1'b1;
    lr_ext    = (IPART_W+1)'(last_row);
    lc_ext    = (IPART_W+1)'(last_col);
    wr_ok_nxt = (row1_r < COORD_W'(MAX_ROWS)) && (col1_r < COORD_W'(MAX_COLS));
    frac_nxt.fr = pr1_r[FRAC_W-1:0];
    frac_nxt.fc = pc1_r[FRAC_W-1:0];
    if (kind1_r == KIND_REQUEST) begin
      r0_nxt = (ir_ext < lr_ext) ? ir_ext[RIDX_W-1:0] : last_row;
      r1_nxt = (ir_inc < lr_ext) ? ir_inc[RIDX_W-1:0] : last_row;
      c0_nxt = (ic_ext < lc_ext) ? ic_ext[CIDX_W-1:0] : last_col;
      c1_nxt = (ic_inc < lc_ext) ? ic_inc[CIDX_W-1:0] : last_col;
    end else begin
      r0_nxt = row1_r[RIDX_W-1:0];
      r1_nxt = row1_r[RIDX_W-1:0];
      c0_nxt = col1_r[CIDX_W-1:0];
      c1_nxt = col1_r[CIDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      kind2_r <= kind1_r;
      pix2_r  <= pix1_r;
      wr_ok_r <= wr_ok_nxt;
      frac_r  <= frac_nxt;
      r0_r    <= r0_nxt;
      r1_r    <= r1_nxt;
      c0_r    <= c0_nxt;
      c1_r    <= c1_nxt;
    end
  end

  assign s2_valid = v2_r;
  assign s2_kind  = kind2_r;
  assign s2_wr_ok = wr_ok_r;
  assign s2_r0    = r0_r;
  assign s2_r1    = r1_r;
  assign s2_c0    = c0_r;
  assign s2_c1    = c1_r;
  assign s2_frac  = frac_r;
  assign s2_pix   = pix2_r;

  `ASSERT_AT(a_row_pair, clk, rst_n, (v2_r && kind2_r == KIND_REQUEST) |-> (r0_r <= last_row && r1_r <= last_row && (r1_r == r0_r || r1_r == r0_r + 1'b1)))
  `ASSERT_AT(a_col_pair, clk, rst_n, (v2_r && kind2_r == KIND_REQUEST) |-> (c0_r <= last_col && c1_r <= last_col && (c1_r == c0_r || c1_r == c0_r + 1'b1)))

endmodule

// ----- sv/bis_store.sv -----
// ---------------------------------------------------------------------------
// Bilinear scaler frame store
// Four parity banks (row, column); one neighbour per bank a cycle unless stalled.
// ---------------------------------------------------------------------------
module bis_store #(
  parameter int MAX_ROWS = bis_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bis_pkg::MAX_COLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 s2_valid,
  input  bis_pkg::kind_t                       s2_kind,
  input  logic                                 s2_wr_ok,
  input  logic [$clog2(MAX_ROWS)-1:0]          s2_r0,
  input  logic [$clog2(MAX_ROWS)-1:0]          s2_r1,
  input  logic [$clog2(MAX_COLS)-1:0]          s2_c0,
  input  logic [$clog2(MAX_COLS)-1:0]          s2_c1,
  input  bis_pkg::frac_t                       s2_frac,
  input  logic [bis_pkg::PIX_W-1:0]            s2_pix,
  input  logic                                 s3_ready,
  output logic                                 s3_valid,
  output bis_pkg::frac_t                       s3_frac,
  output bis_pkg::quad_t                       s3_quad
);
  import bis_pkg::*;

  localparam int RIDX_W     = $clog2(MAX_ROWS);
  localparam int CIDX_W     = $clog2(MAX_COLS);
  localparam int AW         = (RIDX_W + CIDX_W - 2 > 0) ? RIDX_W + CIDX_W - 2 : 1;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int NBANK      = 4;

  function automatic logic [AW-1:0] bank_addr(input logic [RIDX_W-1:0] r,
                                               input logic [CIDX_W-1:0] c);
    logic [RIDX_W+CIDX_W-1:0] t;
    t = {r >> 1, c} >> 1;
    return t[AW-1:0];
  endfunction

  logic               wr_en;
  logic [1:0]         wr_bank;
  logic [AW-1:0]      wr_addr;
  logic [PIX_W-1:0]   rdata_r [NBANK];
  logic               v3_r;
  frac_t              frac3_r;
  logic               rp0_r, rp1_r, cp0_r, cp1_r;

  assign wr_en   = s3_ready && s2_valid && s2_kind == KIND_LOAD && s2_wr_ok;
  assign wr_bank = {s2_r0[0], s2_c0[0]};
  assign wr_addr = bank_addr(s2_r0, s2_c0);

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    localparam logic PR = ((b >> 1) & 1) != 0;
    localparam logic PC = (b & 1) != 0;

    logic [PIX_W-1:0]  mem [BANK_DEPTH];
    logic [RIDX_W-1:0] rsel;
    logic [CIDX_W-1:0] csel;
    logic [AW-1:0]     raddr;

    always_comb begin
      rsel  = (s2_r0[0] == PR) ? s2_r0 : s2_r1;
      csel  = (s2_c0[0] == PC) ? s2_c0 : s2_c1;
      raddr = bank_addr(rsel, csel);
    end

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) mem[wr_addr] <= s2_pix;
    end

    always_ff @(posedge clk) begin
      if (s3_ready) rdata_r[b] <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_ready) begin
      v3_r <= s2_valid && s2_kind == KIND_REQUEST;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      frac3_r <= s2_frac;
      rp0_r   <= s2_r0[0];
      rp1_r   <= s2_r1[0];
      cp0_r   <= s2_c0[0];
      cp1_r   <= s2_c1[0];
    end
  end

  always_comb begin
    s3_quad.p00 = rdata_r[{rp0_r, cp0_r}];
    s3_quad.p01 = rdata_r[{rp0_r, cp1_r}];
    s3_quad.p10 = rdata_r[{rp1_r, cp0_r}];
    s3_quad.p11 = rdata_r[{rp1_r, cp1_r}];
  end

  assign s3_valid = v3_r;
  assign s3_frac  = frac3_r;

endmodule

// ----- sv/bis_blend.sv -----
// ---------------------------------------------------------------------------
// Bilinear scaler blend
// Horizontal blend of both rows, then vertical blend and truncation.
// ---------------------------------------------------------------------------
module bis_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s3_valid,
  input  bis_pkg::frac_t                s3_frac,
  input  bis_pkg::quad_t                s3_quad,
  output logic                          s3_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bis_pkg::PIX_W-1:0]     out_pixel
);
  import bis_pkg::*;

  localparam int HPROD_W = WGT_W + PIX_W;
  localparam int OUT_LSB = 2 * FRAC_W;

  logic                  v4_r, v5_r;
  logic                  en4, en5;
  logic [WGT_W-1:0]      wc0, wc1, wr0, wr1;
  logic [HPROD_W-1:0]    top_sum, bot_sum;
  logic [HBLEND_W-1:0]   top_r, bot_r;
  logic [FRAC_W-1:0]     fr4_r;
  logic [VBLEND_W-1:0]   vsum;
  logic [PIX_W-1:0]      pix_nxt, pix_r;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign s3_ready = !s3_valid || en4;

  always_comb begin
    wc1     = {1'b0, s3_frac.fc};
    wc0     = WGT_ONE - wc1;
    top_sum = HPROD_W'(wc0) * HPROD_W'(s3_quad.p00) + HPROD_W'(wc1) * HPROD_W'(s3_quad.p01);
    bot_sum = HPROD_W'(wc0) * HPROD_W'(s3_quad.p10) + HPROD_W'(wc1) * HPROD_W'(s3_quad.p11);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) v4_r <= s3_valid;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      top_r <= top_sum[HBLEND_W-1:0];
      bot_r <= bot_sum[HBLEND_W-1:0];
      fr4_r <= s3_frac.fr;
    end
  end

  always_comb begin
    wr1     = {1'b0, fr4_r};
    wr0     = WGT_ONE - wr1;
    vsum    = VBLEND_W'(wr0) * VBLEND_W'(top_r) + VBLEND_W'(wr1) * VBLEND_W'(bot_r);
    pix_nxt = vsum[OUT_LSB+PIX_W-1:OUT_LSB];
  end

  always_ff @(posedge clk) begin
    if (en5) pix_r <= pix_nxt;
  end

  assign out_valid = v5_r;
  assign out_pixel = pix_r;

endmodule

// ----- sv/bilinear_image_scaler_core.sv -----
// ---------------------------------------------------------------------------
// Bilinear image scaler core: one word per cycle when not stalled; five-stage pipe.
// A request is registered through the map, store and blend stages; a load writes at the map output.
// Sync reset clears valid bits and resets config; the frame store is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_image_scaler_core #(
  parameter int MAX_ROWS = bis_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bis_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bis_pkg::SCALE_W-1:0]       cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // row [15:0], col [31:16], pixel_value [39:32]
  input  logic [bis_pkg::IN_TDATA_W-1:0]    in_tdata,
  // kind [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_pixel [7:0]
  output logic [bis_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import bis_pkg::*;

  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int CIDX_W = $clog2(MAX_COLS);

  logic [DIM_W-1:0]     rows_r, cols_r;
  logic [SCALE_W-1:0]   scale_r;
  logic [DIM_EXT_W-1:0] rows_ext, cols_ext;
  logic [RIDX_W-1:0]    last_row;
  logic [CIDX_W-1:0]    last_col;

  logic                 s2_valid, s2_wr_ok, s3_valid, s3_ready;
  kind_t                s2_kind;
  logic [RIDX_W-1:0]    s2_r0, s2_r1;
  logic [CIDX_W-1:0]    s2_c0, s2_c1;
  frac_t                s2_frac, s3_frac;
  logic [PIX_W-1:0]     s2_pix;
  quad_t                s3_quad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROWS_RST;
      cols_r  <= COLS_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_ROWS: rows_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_COLS: cols_r  <= cfg_data[DIM_W-1:0];
        CFG_INV_SCALE:  scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_ext = DIM_EXT_W'(rows_r);
    cols_ext = DIM_EXT_W'(cols_r);
    if (rows_ext == '0) begin
      last_row = '0;
    end else if (rows_ext > DIM_EXT_W'(MAX_ROWS)) begin
      last_row = RIDX_W'(MAX_ROWS - 1);
    end else begin
      last_row = RIDX_W'(rows_ext - 1'b1);
    end
    if (cols_ext == '0) begin
      last_col = '0;
    end else if (cols_ext > DIM_EXT_W'(MAX_COLS)) begin
      last_col = CIDX_W'(MAX_COLS - 1);
    end else begin
      last_col = CIDX_W'(cols_ext - 1'b1);
    end
  end

  bis_map #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (kind_t'(in_tuser)),
    .in_row    (in_tdata[COORD_W-1:0]),
    .in_col    (in_tdata[2*COORD_W-1:COORD_W]),
    .in_pix    (in_tdata[IN_TDATA_W-1:2*COORD_W]),
    .inv_scale (scale_r),
    .last_row  (last_row),
    .last_col  (last_col),
    .s3_ready  (s3_ready),
    .s2_valid  (s2_valid),
    .s2_kind   (s2_kind),
    .s2_wr_ok  (s2_wr_ok),
    .s2_r0     (s2_r0),
    .s2_r1     (s2_r1),
    .s2_c0     (s2_c0),
    .s2_c1     (s2_c1),
    .s2_frac   (s2_frac),
    .s2_pix    (s2_pix)
  );

  bis_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_kind  (s2_kind),
    .s2_wr_ok (s2_wr_ok),
    .s2_r0    (s2_r0),
    .s2_r1    (s2_r1),
    .s2_c0    (s2_c0),
    .s2_c1    (s2_c1),
    .s2_frac  (s2_frac),
    .s2_pix   (s2_pix),
    .s3_ready (s3_ready),
    .s3_valid (s3_valid),
    .s3_frac  (s3_frac),
    .s3_quad  (s3_quad)
  );

  bis_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_frac   (s3_frac),
    .s3_quad   (s3_quad),
    .s3_ready  (s3_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata)
  );

  `ASSERT_NEVER(a_no_bubble_stall, clk, rst_n, (!out_tvalid || out_tready) && !in_tready)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear image scaler core testbench
// Loads source pixels into the frame store, requests output coordinates under
// a range of image sizes and inverse scales, and checks every returned pixel
// against a fixed-point bilinear predictor kept in a small scoreboard class.
// Both stream sides idle at random; one phase runs without idling.
// ---------------------------------------------------------------------------
module tb;
  import bis_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int STORE_DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF;

  typedef struct {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } due_pixel_t;

  typedef struct {
    int unsigned       r0;
    int unsigned       r1;
    int unsigned       c0;
    int unsigned       c1;
    logic [FRAC_W-1:0] fr;
    logic [FRAC_W-1:0] fc;
  } taps_t;

  class scaler_scoreboard;
    logic [PIX_W-1:0]   pixel_mem [STORE_DEPTH];
    bit                 loaded [STORE_DEPTH];
    logic [DIM_W-1:0]   rows_reg = ROWS_RST;
    logic [DIM_W-1:0]   cols_reg = COLS_RST;
    logic [SCALE_W-1:0] scale_reg = SCALE_RST;
    due_pixel_t         due_pixels [$];
    int                 errors = 0;

    function int unsigned fold_dim(logic [DIM_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function int unsigned rows_eff();
      return fold_dim(rows_reg, MAX_ROWS_DEF);
    endfunction

    function int unsigned cols_eff();
      return fold_dim(cols_reg, MAX_COLS_DEF);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [SCALE_W-1:0] d);
      case (idx)
        CFG_IMAGE_ROWS: rows_reg = d[DIM_W-1:0];
        CFG_IMAGE_COLS: cols_reg = d[DIM_W-1:0];
        CFG_INV_SCALE:  scale_reg = d;
        default: ;
      endcase
    endfunction

    function taps_t locate(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      taps_t       t;
      logic [63:0] pr, pc, ir, ic, lr, lc;
      pr = 64'(row) * 64'(scale_reg);
      pc = 64'(col) * 64'(scale_reg);
      ir = pr >> FRAC_W;
      ic = pc >> FRAC_W;
      t.fr = pr[FRAC_W-1:0];
      t.fc = pc[FRAC_W-1:0];
      lr = 64'(rows_eff() - 1);
      lc = 64'(cols_eff() - 1);
      t.r0 = 32'((ir < lr) ? ir : lr);
      t.r1 = 32'((ir + 1 < lr) ? ir + 1 : lr);
      t.c0 = 32'((ic < lc) ? ic : lc);
      t.c1 = 32'((ic + 1 < lc) ? ic + 1 : lc);
      return t;
    endfunction

    function bit taps_loaded(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      taps_t t;
      t = locate(row, col);
      return loaded[t.r0 * MAX_COLS_DEF + t.c0] && loaded[t.r0 * MAX_COLS_DEF + t.c1] &&
             loaded[t.r1 * MAX_COLS_DEF + t.c0] && loaded[t.r1 * MAX_COLS_DEF + t.c1];
    endfunction

    function void note_word(kind_t kind, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                            logic [PIX_W-1:0] pix);
      taps_t       t;
      logic [63:0] wc0, wc1, wr0, wr1, top, bot, sum;
      due_pixel_t  d;
      if (kind == KIND_LOAD) begin
        if (row < MAX_ROWS_DEF && col < MAX_COLS_DEF) begin
          pixel_mem[row * MAX_COLS_DEF + col] = pix;
          loaded[row * MAX_COLS_DEF + col] = 1'b1;
        end
        return;
      end
      t = locate(row, col);
      wc1 = 64'(t.fc);
      wc0 = 64'h10000 - wc1;
      wr1 = 64'(t.fr);
      wr0 = 64'h10000 - wr1;
      top = wc0 * 64'(pixel_mem[t.r0 * MAX_COLS_DEF + t.c0]) +
            wc1 * 64'(pixel_mem[t.r0 * MAX_COLS_DEF + t.c1]);
      bot = wc0 * 64'(pixel_mem[t.r1 * MAX_COLS_DEF + t.c0]) +
            wc1 * 64'(pixel_mem[t.r1 * MAX_COLS_DEF + t.c1]);
      sum = wr0 * top + wr1 * bot;
      d.value = sum[39:32];
      d.row = row;
      d.col = col;
      due_pixels.push_back(d);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_pixel(logic [PIX_W-1:0] got);
      due_pixel_t d;
      if (due_pixels.size() == 0) begin
        report($sformatf("pixel %0d with no request pending", got));
        return;
      end
      d = due_pixels.pop_front();
      if (got !== d.value)
        report($sformatf("request (%0d,%0d): pixel %0d, want %0d", d.row, d.col, got, d.value));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_IMAGE_ROWS;
  logic [SCALE_W-1:0]       cfg_data = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata = '0;
  logic                     in_tuser = KIND_LOAD;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;

  scaler_scoreboard sb = new();
  bit               calm = 1'b0;
  int               cycle_count = 0;

  bilinear_image_scaler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_pixel(out_tdata);
      out_tready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  task automatic send_word(kind_t k, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                           logic [PIX_W-1:0] p);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {p, c, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(k, r, c, p);
  endtask

  // drop valid, wait for every pending pixel, then let loads in flight retire
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [SCALE_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic set_geometry(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                              logic [SCALE_W-1:0] scale);
    wait_quiet();
    write_reg(CFG_IMAGE_ROWS, {15'($urandom), rows});
    write_reg(CFG_IMAGE_COLS, {15'($urandom), cols});
    write_reg(CFG_INV_SCALE, scale);
    cfg_we <= 1'b0;
  endtask

  task automatic load_block(int unsigned r_lo, int unsigned r_hi, int unsigned c_lo,
                            int unsigned c_hi);
    for (int unsigned r = r_lo; r <= r_hi; r++)
      for (int unsigned c = c_lo; c <= c_hi; c++)
        send_word(KIND_LOAD, 16'(r), 16'(c), 8'($urandom));
  endtask

  // hunt for a coordinate whose four taps were all loaded; fall back to the origin
  task automatic send_request();
    logic [COORD_W-1:0] r, c;
    longint unsigned    span;
    bit                 found;
    found = 1'b0;
    r = '0;
    c = '0;
    span = 65535;
    if (sb.scale_reg != 0) begin
      span = ((longint'(sb.rows_eff() > sb.cols_eff() ? sb.rows_eff() : sb.cols_eff()) + 1)
              << FRAC_W) / sb.scale_reg;
      if (span > 65535) span = 65535;
    end
    for (int n = 0; n < 64 && !found; n++) begin
      case ($urandom_range(0, 3))
        0: begin
          r = 16'($urandom);
          c = 16'($urandom);
        end
        1: begin
          r = 16'($urandom_range(0, 32'(span)));
          c = 16'($urandom_range(0, 32'(span)));
        end
        2: begin
          r = 16'hFFFF - 16'($urandom_range(0, 3));
          c = 16'($urandom_range(0, 32'(span)));
        end
        default: begin
          r = 16'($urandom_range(0, 32'(span)));
          c = 16'hFFFF - 16'($urandom_range(0, 3));
        end
      endcase
      found = sb.taps_loaded(r, c);
    end
    if (!found) begin
      r = '0;
      c = '0;
    end
    send_word(KIND_REQUEST, r, c, 8'($urandom));
  endtask

  task automatic run_phase(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                           logic [SCALE_W-1:0] scale, int items);
    int unsigned        er, ec, r, c, roll;
    int                 done;
    logic [COORD_W-1:0] fr, fc;
    set_geometry(rows, cols, scale);
    er = sb.rows_eff();
    ec = sb.cols_eff();
    if (er * ec <= 1024) begin
      load_block(0, er - 1, 0, ec - 1);
    end else begin
      load_block(0, 1, 0, 1);
      load_block(0, 1, ec - 2, ec - 1);
      load_block(er - 2, er - 1, 0, 1);
      load_block(er - 2, er - 1, ec - 2, ec - 1);
      repeat (16) begin
        r = $urandom_range(0, er - 2);
        c = $urandom_range(0, ec - 2);
        load_block(r, r + 1, c, c + 1);
      end
    end
    done = 0;
    while (done < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_request();
        done++;
      end else if (roll < 85) begin
        send_word(KIND_LOAD, 16'($urandom_range(0, er - 1)), 16'($urandom_range(0, ec - 1)),
                  8'($urandom));
        done++;
      end else begin
        fr = 16'($urandom);
        fc = 16'($urandom);
        if (fr < MAX_ROWS_DEF && fc < MAX_COLS_DEF) fr[$urandom_range(8, 15)] = 1'b1;
        send_word(KIND_LOAD, fr, fc, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] scale;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(KIND_LOAD, 16'd0, 16'd0, 8'd0);
    send_word(KIND_LOAD, 16'd0, 16'd1, 8'd255);
    send_word(KIND_LOAD, 16'd1, 16'd0, 8'd255);
    send_word(KIND_LOAD, 16'd1, 16'd1, 8'd0);
    send_word(KIND_LOAD, 16'd254, 16'd254, 8'h80);
    send_word(KIND_LOAD, 16'd254, 16'd255, 8'hFF);
    send_word(KIND_LOAD, 16'd255, 16'd254, 8'h00);
    send_word(KIND_LOAD, 16'd255, 16'd255, 8'hFF);
    send_word(KIND_LOAD, 16'd256, 16'd0, 8'hAA);
    send_word(KIND_LOAD, 16'd0, 16'd256, 8'h55);
    send_word(KIND_LOAD, 16'hFFFF, 16'hFFFF, 8'hAA);
    send_word(KIND_REQUEST, 16'd0, 16'd0, 8'hFF);
    send_word(KIND_REQUEST, 16'd254, 16'd254, 8'h00);
    send_word(KIND_REQUEST, 16'd255, 16'd255, 8'h00);
    send_word(KIND_REQUEST, 16'hFFFF, 16'hFFFF, 8'hFF);

    set_geometry(9'd2, 9'd2, 24'h008000);
    send_word(KIND_REQUEST, 16'd0, 16'd1, 8'h00);
    send_word(KIND_REQUEST, 16'd1, 16'd0, 8'h00);
    send_word(KIND_REQUEST, 16'd1, 16'd1, 8'h00);
    send_word(KIND_REQUEST, 16'd2, 16'd2, 8'h00);
    send_word(KIND_REQUEST, 16'd3, 16'd3, 8'h00);
    set_geometry(9'd2, 9'd2, 24'd0);
    send_word(KIND_REQUEST, 16'hFFFF, 16'hFFFF, 8'h00);
    set_geometry(9'd2, 9'd2, 24'hFFFFFF);
    send_word(KIND_REQUEST, 16'hFFFF, 16'd1, 8'h00);
    send_word(KIND_REQUEST, 16'd1, 16'hFFFF, 8'h00);

    run_phase(9'd12, 9'd12, 24'h008000, 50);
    run_phase(9'd1, 9'd1, 24'($urandom), 20);
    run_phase(9'd0, 9'd0, 24'h010000, 15);
    run_phase(9'd256, 9'd1, 24'h004000, 40);
    run_phase(9'd1, 9'd256, 24'h028000, 40);
    run_phase(9'd511, 9'd511, 24'hFFFFFF, 30);
    run_phase(9'd3, 9'd5, 24'd1, 30);
    run_phase(9'd7, 9'd9, 24'd0, 15);
    run_phase(9'd256, 9'd256, 24'h010000, 30);
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 3))
        0: scale = 24'($urandom_range(24'h002000, 24'h020000));
        1: scale = 24'($urandom);
        2: scale = 24'($urandom_range(1, 24'h001000));
        default: scale = 24'h010000;
      endcase
      calm = (p == 2);
      run_phase(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)), scale, 35);
    end
    calm = 1'b0;

    wait_quiet();
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
